@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define AST_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the same cycle.
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the next cycle.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/dssf_pkg.sv @@
package dssf_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int DIG_W       = $clog2(DIGIT_COUNT);

    localparam logic [7:0] CMD_AUTO_INC = 8'h40;
    localparam logic [7:0] CMD_ADDR0    = 8'hc0;
    localparam logic [7:0] CMD_DISP_ON  = 8'h89;
    localparam logic [7:0] SEG_BLANK    = 8'h00;

    // Byte positions within one command's output run
    localparam int SHOW_LAST  = 2 * DIGIT_COUNT;
    localparam int CLEAR_LAST = 18;
    localparam int IDX_W      = $clog2(CLEAR_LAST + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_SHOW  = 1'b1;

    typedef struct packed {
        logic                             show;
        logic [DIGIT_COUNT-1:0][7:0]      segs;  // index 0 is the rightmost position
    } cmd_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/dssf_front.sv @@
module dssf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic          s_tuser,
    output dssf_pkg::cmd_t push_data,
    output logic          push_valid,
    input  logic          push_ready
);
    import dssf_pkg::*;

    front_state_t              state_reg, state_next;
    logic [DIG_W-1:0]          cnt_reg, cnt_next;
    logic [15:0]               rem_reg, rem_next;
    cmd_t                      cmd_reg, cmd_next;

    logic [31:0]               prod;
    logic [15:0]               quot;
    logic [15:0]               quot_x10;
    logic [3:0]                digit;
    logic [7:0]                seg;

    // Divide by ten through the reciprocal; exact over the full 16-bit range
    assign prod     = 32'(rem_reg) * 32'd52429;
    assign quot     = 16'(prod[31:19]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign digit    = 4'(rem_reg - quot_x10);
    assign seg      = (rem_reg == 16'd0) ? SEG_BLANK : seg_code(digit);

    assign s_tready   = (state_reg == FRONT_IDLE);
    assign push_valid = (state_reg == FRONT_PUSH);
    assign push_data  = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        cmd_reg <= cmd_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            FRONT_IDLE: begin
                if (s_tvalid) begin
                    cmd_next.show = s_tuser;
                    rem_next      = s_tdata;
                    cnt_next      = '0;
                    state_next    = (s_tuser == OP_SHOW) ? FRONT_CONV : FRONT_PUSH;
                end
            end
            FRONT_CONV: begin
                // one decimal digit per cycle, least significant first
                cmd_next.segs[cnt_reg] = seg;
                rem_next               = quot;
                cnt_next               = cnt_reg + 1'b1;
                if (cnt_reg == DIG_W'(DIGIT_COUNT - 1)) begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                if (push_ready) begin
                    state_next = FRONT_IDLE;
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dssf_queue.sv @@
module dssf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  dssf_pkg::cmd_t push_data,
    input  logic           push_valid,
    output logic           push_ready,
    output dssf_pkg::cmd_t head_data,
    output logic           head_valid,
    input  logic           pop
);
    import dssf_pkg::*;

    cmd_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/dssf_back.sv @@
module dssf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  dssf_pkg::cmd_t head_data,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);
    import dssf_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        byte_reg;
    logic              fs_reg;
    logic              fe_reg;
    logic              last_reg;

    logic              adv;
    logic              at_end;
    logic [DIG_W-1:0]  pos;
    logic [7:0]        byte_c;
    logic              fs_c;
    logic              fe_c;
    logic              last_c;

    assign adv = head_valid && (!m_tvalid_reg || m_tready);
    // odd byte slots carry segments, left to right
    assign pos = DIG_W'(DIGIT_COUNT - 1) - idx_reg[DIG_W:1];

    always_comb begin
        byte_c = SEG_BLANK;
        fs_c   = 1'b0;
        fe_c   = 1'b0;
        last_c = 1'b0;
        if (head_data.show) begin
            at_end = (idx_reg == IDX_W'(SHOW_LAST));
            if (idx_reg == '0) begin
                byte_c = CMD_ADDR0;
                fs_c   = 1'b1;
            end else if (idx_reg[0]) begin
                byte_c = head_data.segs[pos];
            end else begin
                fe_c   = at_end;
                last_c = at_end;
            end
        end else begin
            at_end = (idx_reg == IDX_W'(CLEAR_LAST));
            if (idx_reg == '0) begin
                byte_c = CMD_AUTO_INC;
                fs_c   = 1'b1;
                fe_c   = 1'b1;
            end else if (idx_reg == IDX_W'(1)) begin
                byte_c = CMD_ADDR0;
                fs_c   = 1'b1;
            end else if (at_end) begin
                byte_c = CMD_DISP_ON;
                fs_c   = 1'b1;
                fe_c   = 1'b1;
                last_c = 1'b1;
            end else begin
                fe_c = (idx_reg == IDX_W'(CLEAR_LAST - 1));
            end
        end
    end

    assign pop = adv && at_end;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (adv) begin
            idx_next      = at_end ? '0 : idx_reg + 1'b1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (adv) begin
            byte_reg <= byte_c;
            fs_reg   <= fs_c;
            fe_reg   <= fe_c;
            last_reg <= last_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {fe_reg, fs_reg};
    assign m_tlast  = last_reg;

endmodule

@@ rtl/decimal_seven_segment_frame_builder_top.sv @@
// Seven-segment frame builder: each command transfer becomes the byte stream for an
// 8-position LED-and-key display driver. A show command (s_tuser = 1) emits 0xc0 and
// then a segment byte and a zero dot byte per position, the value right-aligned in
// decimal with blank leading positions (0 shows all blanks): 17 bytes. A clear command
// (s_tuser = 0) emits 0x40, 0xc0 with sixteen zero bytes, and 0x89: 19 bytes. The
// output sends one byte per cycle while m_tready is high; the decimal conversion (one
// digit per cycle, between accepting a command and handing it on) runs ahead through
// a two-command queue, so commands stream without gaps on the output while m_tready
// stays high.
module decimal_seven_segment_frame_builder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] byte_out
    output logic [1:0]  m_tuser,   // [0] frame_start, [1] frame_end
    output logic        m_tlast
);
    import dssf_pkg::*;

    cmd_t push_data;
    logic push_valid;
    logic push_ready;
    cmd_t head_data;
    logic head_valid;
    logic pop;

    dssf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dssf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head_data  (head_data),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dssf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_data  (head_data),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ rtl/dssf_checker.sv @@
`include "assert_macros.svh"

module dssf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import dssf_pkg::*;

    logic [10:0] out_word;
    logic        start_byte_ok;

    assign out_word      = {m_tlast, m_tuser, m_tdata};
    assign start_byte_ok = (m_tdata == CMD_AUTO_INC) || (m_tdata == CMD_ADDR0) ||
                           (m_tdata == CMD_DISP_ON);

    // hold a stalled result byte
    `AST_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

    // the final byte of a command always closes a strobe frame
    `AST_IMPLY(a_last_ends_frame, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1])

    // a frame opens only on a command or address byte
    `AST_IMPLY(a_start_is_cmd, aclk, aresetn, m_tvalid && m_tuser[0], start_byte_ok)

    // the byte after a command's final transfer opens a new frame
    `AST_NEXT(a_next_cmd_starts, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tuser[0])

endmodule

bind decimal_seven_segment_frame_builder_top dssf_checker u_dssf_checker (.*);

@@ dv/tb_decimal_seven_segment_frame_builder_top.sv @@
`timescale 1ns / 100ps

module tb_decimal_seven_segment_frame_builder_top;
    import dssf_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 12;
    localparam int CLEAR_ZERO_BYTES = 16;
    localparam int RANDOM_CMDS      = 300;
    localparam int CALM_CMDS        = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER  = 90;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int REPORT_LIMIT     = 10;

    // segment patterns, digit 0 in the low byte
    localparam logic [9:0][7:0] DIGIT_SEGS = {
        8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    typedef struct {
        logic        op;
        logic [15:0] value;
    } display_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fstart;
        logic       fend;
        logic       tail;
    } frame_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] value
    logic        s_tuser  = 1'b0; // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] byte_out
    logic [1:0]  m_tuser;         // [0] frame_start, [1] frame_end
    logic        m_tlast;

    display_cmd_t pending_cmds[$];
    frame_byte_t  expected_bytes[$];

    bit calm_phase     = 1'b0;
    bit long_hold_done = 1'b0;
    int mismatches     = 0;
    int cmds_accepted  = 0;
    int clears_seen    = 0;
    int shows_seen     = 0;
    int blank_shows    = 0;
    int bytes_checked  = 0;
    int input_stalls   = 0;
    int tx_gap         = 0;
    int tx_quiet       = 0;
    int rx_gap         = 0;
    int rx_quiet       = 0;
    int rx_hold        = 0;
    int idle_cycles    = 0;

    decimal_seven_segment_frame_builder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Append the byte stream one command produces.
    function automatic void predict_frames(input logic op, input logic [15:0] value);
        logic [7:0]  segs [DIGIT_COUNT];
        logic [15:0] rest;
        logic        at_end;
        rest = value;
        if (op == OP_CLEAR) begin
            clears_seen++;
            expected_bytes.push_back('{CMD_AUTO_INC, 1'b1, 1'b1, 1'b0});
            expected_bytes.push_back('{CMD_ADDR0, 1'b1, 1'b0, 1'b0});
            for (int i = 0; i < CLEAR_ZERO_BYTES; i++)
                expected_bytes.push_back('{SEG_BLANK, 1'b0, i == CLEAR_ZERO_BYTES - 1, 1'b0});
            expected_bytes.push_back('{CMD_DISP_ON, 1'b1, 1'b1, 1'b1});
        end else begin
            shows_seen++;
            if (value == 16'd0)
                blank_shows++;
            // index 0 is the rightmost position; leading positions stay blank
            for (int p = 0; p < DIGIT_COUNT; p++) begin
                if (rest != 16'd0) begin
                    segs[p] = DIGIT_SEGS[4'(rest % 16'd10)];
                    rest    = rest / 16'd10;
                end else begin
                    segs[p] = SEG_BLANK;
                end
            end
            expected_bytes.push_back('{CMD_ADDR0, 1'b1, 1'b0, 1'b0});
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                at_end = (i == DIGIT_COUNT - 1);
                expected_bytes.push_back('{segs[DIGIT_COUNT - 1 - i], 1'b0, 1'b0, 1'b0});
                expected_bytes.push_back('{SEG_BLANK, 1'b0, at_end, at_end});
            end
        end
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function automatic logic [15:0] pick_value();
        int kind;
        int pow;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom_range(1, 9));
            3: return 16'($urandom_range(10, 99));
            4: return 16'($urandom_range(100, 999));
            5: return 16'($urandom_range(1000, 9999));
            6: return 16'($urandom_range(10000, 65535));
            7: begin
                pow = 1;
                repeat ($urandom_range(0, 4)) pow = pow * 10;
                return 16'(pow - $urandom_range(0, 1));
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_random(input int count);
        display_cmd_t c;
        for (int n = 0; n < count; n++) begin
            c.op    = ($urandom_range(0, 4) == 0) ? OP_CLEAR : OP_SHOW;
            c.value = (c.op == OP_CLEAR) ? 16'($urandom) : pick_value();
            pending_cmds.push_back(c);
        end
    endfunction

    // Sender: hold an offered command until it is taken, then advance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            input_stalls++;
        end else begin
            if (tx_quiet > 0)
                tx_quiet--;
            else if (!calm_phase && $urandom_range(0, 39) == 0)
                tx_quiet = $urandom_range(20, 120);
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm_phase && tx_quiet == 0 && $urandom_range(0, 7) == 0) begin
                tx_gap = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_cmds[0].value;
                s_tuser  <= pending_cmds[0].op;
                void'(pending_cmds.pop_front());
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off to back up the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_quiet > 0)
                rx_quiet--;
            else if (!calm_phase && $urandom_range(0, 39) == 0)
                rx_quiet = $urandom_range(20, 150);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && cmds_accepted >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                rx_hold        = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (!calm_phase && rx_quiet == 0 && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Predict on each command transfer, check each byte transfer against the oldest one.
    always @(posedge aclk) begin
        frame_byte_t want;
        frame_byte_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cmds_accepted++;
                predict_frames(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
                if (expected_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h start %0b end %0b last %0b",
                                            got.data, got.fstart, got.fend, got.tail));
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (got != want)
                        flag_mismatch($sformatf(
                            "byte %02h/%02h start %0b/%0b end %0b/%0b last %0b/%0b (exp/got)",
                            want.data, got.data, want.fstart, got.fstart,
                            want.fend, got.fend, want.tail, got.tail));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("decimal_seven_segment_frame_builder_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        display_cmd_t c;
        logic [15:0]  directed_values [$];
        directed_values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd1000,
                            16'd9999, 16'd10000, 16'd10005, 16'd12345, 16'd56789,
                            16'd60708, 16'hffff, 16'h8000, 16'h5555, 16'haaaa, 16'd4321};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // clears with both empty and full value bits, shows over digit extremes, then a clear and a zero show
        c.op = OP_CLEAR; c.value = 16'h0000; pending_cmds.push_back(c);
        c.op = OP_CLEAR; c.value = 16'hffff; pending_cmds.push_back(c);
        foreach (directed_values[i]) begin
            c.op    = OP_SHOW;
            c.value = directed_values[i];
            pending_cmds.push_back(c);
        end
        c.op = OP_CLEAR; c.value = 16'h1234; pending_cmds.push_back(c);
        c.op = OP_SHOW;  c.value = 16'd0;    pending_cmds.push_back(c);

        // sender pause: let every expected byte drain before the random part
        while (pending_cmds.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge aclk);

        queue_random(RANDOM_CMDS);
        while (pending_cmds.size() != 0)
            @(posedge aclk);
        calm_phase = 1'b1;
        queue_random(CALM_CMDS);

        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

        $display("covered %0d commands: %0d clears, %0d shows (%0d of value zero)",
                 cmds_accepted, clears_seen, shows_seen, blank_shows);
        $display("checked %0d output bytes; input stalled %0d cycles; %0d mismatches",
                 bytes_checked, input_stalls, mismatches);
        if (mismatches == 0)
            $display("decimal_seven_segment_frame_builder_top regression: pass");
        else
            $display("decimal_seven_segment_frame_builder_top regression: fail");
        $finish;
    end

endmodule
